FILE: hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the status and buzzer block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication check failed");

`endif

FILE: hdl/sbr_pkg.sv
// Types and constants shared by the status and buzzer register block.
`timescale 1ns / 1ps

package sbr_pkg;

   localparam int CYCLE_W     = 64;
   localparam int CSR_INDEX_W = 2;
   localparam int BUZ_RES_W   = 17;
   localparam int TIME_RES_W  = 12;

   // Buzzer duration unit and time-register divisor, both used as moduli of the cpu_cycle field.
   localparam logic [BUZ_RES_W-1:0]  MOD_BUZ  = 17'd125000;
   localparam logic [TIME_RES_W-1:0] MOD_TIME = 12'(1000000 / 256);

   // Weights of the 16-bit chunks of a cycle count and of the fold and wrap terms, reduced by each modulus.
   localparam logic [BUZ_RES_W-1:0] KB1 = 17'((64'd1 << 16) % 64'(MOD_BUZ));
   localparam logic [BUZ_RES_W-1:0] KB2 = 17'((64'd1 << 32) % 64'(MOD_BUZ));
   localparam logic [BUZ_RES_W-1:0] KB3 = 17'((64'd1 << 48) % 64'(MOD_BUZ));
   localparam logic [BUZ_RES_W-1:0] KB_FOLD = 17'((64'd1 << 17) % 64'(MOD_BUZ));
   localparam logic [BUZ_RES_W-1:0] KB_WRAP = 17'((64'(KB3) << 16) % 64'(MOD_BUZ));

   localparam logic [TIME_RES_W-1:0] KT1 = 12'((64'd1 << 16) % 64'(MOD_TIME));
   localparam logic [TIME_RES_W-1:0] KT2 = 12'((64'd1 << 32) % 64'(MOD_TIME));
   localparam logic [TIME_RES_W-1:0] KT3 = 12'((64'd1 << 48) % 64'(MOD_TIME));
   localparam logic [TIME_RES_W-1:0] KT_FOLD = 12'((64'd1 << 12) % 64'(MOD_TIME));

   // Rounded-up reciprocals; exact for the folded operand widths used.
   localparam int RECIP_BUZ_SHIFT  = 48;
   localparam int RECIP_TIME_SHIFT = 38;
   localparam logic [31:0] RECIP_BUZ = 32'(((64'd1 << RECIP_BUZ_SHIFT)
      + 64'(MOD_BUZ) - 64'd1) / 64'(MOD_BUZ));
   localparam logic [26:0] RECIP_TIME = 27'(((64'd1 << RECIP_TIME_SHIFT)
      + 64'(MOD_TIME) - 64'd1) / 64'(MOD_TIME));

   typedef enum logic [1:0] {
      ACT_TICK  = 2'd0,
      ACT_WRITE = 2'd1,
      ACT_READ  = 2'd2
   } sbr_action_type;

   localparam logic [2:0] REG_PRESENCE = 3'd0;
   localparam logic [2:0] REG_TIME     = 3'd1;
   localparam logic [2:0] REG_BUZZER   = 3'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_POWER_ON = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRESENCE = 2'd1;

   typedef struct packed {
      logic [1:0]         action;
      logic [2:0]         reg_index;
      logic [7:0]         write_byte;
      logic [CYCLE_W-1:0] cpu_cycle;
   } sbr_item_type;

   typedef struct packed {
      logic [BUZ_RES_W-1:0]  buz;
      logic [TIME_RES_W-1:0] tim;
   } sbr_residue_type;

endpackage

FILE: hdl/status_and_buzzer_registers_top.sv
// Top level of the status and buzzer register block.
//
//   Channel  Direction  Handshake              Carries
//   req_     in         req_valid/req_stall    action, reg_index, write_byte, cpu_cycle
//   rsp_     out        rsp_valid/rsp_stall    read_byte, buzzer_active, pitch
//   csr_     in         csr_valid/csr_ready    register index and write data
//
// Every transfer on req_ produces exactly one transfer on rsp_: four stages reduce
// the cycle count modulo both divisors, and one stage updates the registers and
// loads the result register.
// A new item is taken every cycle while nothing stalls; the rate is one item per clock.
// Reset is synchronous and active high and clears all register state at once.
// A stalled result holds the pipeline behind it, but empty stages still fill.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module status_and_buzzer_registers_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_action,
   input  logic [2:0]                          req_reg_index,
   input  logic [7:0]                          req_write_byte,
   input  logic [sbr_pkg::CYCLE_W-1:0]         req_cpu_cycle,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [7:0]                          rsp_read_byte,
   output logic                                rsp_buzzer_active,
   output logic [3:0]                          rsp_pitch_factor,
   output logic                                rsp_pitch_lower,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sbr_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [7:0]                          csr_wdata
);
   import sbr_pkg::*;

   sbr_item_type    req_item;
   sbr_item_type    mod_item;
   sbr_residue_type mod_res;
   logic            mod_valid;
   logic            mod_stall;
   logic            core_xfer;

   // Configuration writes must be issued only while the block is idle; the block
   // does not enforce this itself, and the register port can always take them.
   assign csr_ready = 1'b1;

   always_comb begin
      req_item.action     = req_action;
      req_item.reg_index  = req_reg_index;
      req_item.write_byte = req_write_byte;
      req_item.cpu_cycle  = req_cpu_cycle;
   end

   // Residues of the cycle count depend only on the item itself, so they are
   // computed ahead of the state update without any hazard between items.
   sbr_modred u_modred (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_item   (req_item),
      .out_valid (mod_valid),
      .out_stall (mod_stall),
      .out_item  (mod_item),
      .out_res   (mod_res)
   );

   // All register state lives in one stage, so each item sees the effect of
   // the item before it.
   sbr_core u_core (
      .clock             (clock),
      .reset             (reset),
      .in_valid          (mod_valid),
      .in_stall          (mod_stall),
      .in_item           (mod_item),
      .in_res            (mod_res),
      .csr_write         (csr_valid && csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_read_byte     (rsp_read_byte),
      .rsp_buzzer_active (rsp_buzzer_active),
      .rsp_pitch_factor  (rsp_pitch_factor),
      .rsp_pitch_lower   (rsp_pitch_lower)
   );

   assign core_xfer = mod_valid && !mod_stall;

   `ASSERT_IMPLIES(a_residue_range, clock, reset, mod_valid, (mod_res.buz < MOD_BUZ) && (mod_res.tim < MOD_TIME))
   `ASSERT_NEXT(a_result_loads, clock, reset, core_xfer, rsp_valid)
   `ASSERT_IMPLIES(a_pitch_range, clock, reset, rsp_valid, (rsp_pitch_factor >= 4'd1) && (rsp_pitch_factor <= 4'd8))
   `ASSERT_IMPLIES(a_pitch_lower, clock, reset, rsp_valid && rsp_pitch_lower, rsp_pitch_factor != 4'd1)

endmodule

FILE: hdl/sbr_modred.sv
// Four-stage pipeline reducing each item's cycle count modulo both divisors.
`timescale 1ns / 1ps

module sbr_modred (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_stall,
   input  sbr_pkg::sbr_item_type    in_item,
   output logic                     out_valid,
   input  logic                     out_stall,
   output sbr_pkg::sbr_item_type    out_item,
   output sbr_pkg::sbr_residue_type out_res
);
   import sbr_pkg::*;

   logic            s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic            s1_hold, s2_hold, s3_hold, s4_hold;
   sbr_item_type    s1_item_ff, s2_item_ff, s3_item_ff, s4_item_ff;

   logic [34:0]     s1_buz_in, s1_buz_ff;
   logic [29:0]     s1_tim_in, s1_tim_ff;
   logic [30:0]     s2_buz_in, s2_buz_ff, s3_buz_ff;
   logic [25:0]     s2_tim_in, s2_tim_ff, s3_tim_ff;
   logic [62:0]     buz_prod;
   logic [52:0]     tim_prod;
   logic [14:0]     s3_bq_in, s3_bq_ff, s3_tq_in, s3_tq_ff;
   logic [30:0]     buz_diff;
   logic [25:0]     tim_diff;
   sbr_residue_type s4_res_in, s4_res_ff;

   // A stage holds when it is full and the stage after it cannot take its item.
   assign s4_hold  = s4_valid_ff && out_stall;
   assign s3_hold  = s3_valid_ff && s4_hold;
   assign s2_hold  = s2_valid_ff && s3_hold;
   assign s1_hold  = s1_valid_ff && s2_hold;
   assign in_stall = s1_hold;

   always_comb begin
      // Stage 1: weighted sum of the four 16-bit chunks.
      s1_buz_in = 35'(in_item.cpu_cycle[15:0])
         + 35'(in_item.cpu_cycle[31:16]) * 35'(KB1)
         + 35'(in_item.cpu_cycle[47:32]) * 35'(KB2)
         + 35'(in_item.cpu_cycle[63:48]) * 35'(KB3);
      s1_tim_in = 30'(in_item.cpu_cycle[15:0])
         + 30'(in_item.cpu_cycle[31:16]) * 30'(KT1)
         + 30'(in_item.cpu_cycle[47:32]) * 30'(KT2)
         + 30'(in_item.cpu_cycle[63:48]) * 30'(KT3);

      // Stage 2: fold the bits above the modulus width back in.
      s2_buz_in = 31'(s1_buz_ff[16:0]) + 31'(s1_buz_ff[34:17]) * 31'(KB_FOLD);
      s2_tim_in = 26'(s1_tim_ff[11:0]) + 26'(s1_tim_ff[29:12]) * 26'(KT_FOLD);

      // Stage 3: quotient by reciprocal multiplication.
      buz_prod = 63'(s2_buz_ff) * 63'(RECIP_BUZ);
      tim_prod = 53'(s2_tim_ff) * 53'(RECIP_TIME);
      s3_bq_in = buz_prod[RECIP_BUZ_SHIFT +: 15];
      s3_tq_in = tim_prod[RECIP_TIME_SHIFT +: 15];

      // Stage 4: remainder, with one corrective subtraction.
      buz_diff = s3_buz_ff - 31'(s3_bq_ff) * 31'(MOD_BUZ);
      tim_diff = s3_tim_ff - 26'(s3_tq_ff) * 26'(MOD_TIME);
      if (buz_diff >= 31'(MOD_BUZ)) begin
         buz_diff = buz_diff - 31'(MOD_BUZ);
      end
      if (tim_diff >= 26'(MOD_TIME)) begin
         tim_diff = tim_diff - 26'(MOD_TIME);
      end
      s4_res_in.buz = buz_diff[BUZ_RES_W-1:0];
      s4_res_in.tim = tim_diff[TIME_RES_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (!s1_hold) s1_valid_ff <= in_valid;
         if (!s2_hold) s2_valid_ff <= s1_valid_ff;
         if (!s3_hold) s3_valid_ff <= s2_valid_ff;
         if (!s4_hold) s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (!s1_hold) begin
         s1_item_ff <= in_item;
         s1_buz_ff  <= s1_buz_in;
         s1_tim_ff  <= s1_tim_in;
      end
      if (!s2_hold) begin
         s2_item_ff <= s1_item_ff;
         s2_buz_ff  <= s2_buz_in;
         s2_tim_ff  <= s2_tim_in;
      end
      if (!s3_hold) begin
         s3_item_ff <= s2_item_ff;
         s3_buz_ff  <= s2_buz_ff;
         s3_tim_ff  <= s2_tim_ff;
         s3_bq_ff   <= s3_bq_in;
         s3_tq_ff   <= s3_tq_in;
      end
      if (!s4_hold) begin
         s4_item_ff <= s3_item_ff;
         s4_res_ff  <= s4_res_in;
      end
   end

   assign out_valid = s4_valid_ff;
   assign out_item  = s4_item_ff;
   assign out_res   = s4_res_ff;

endmodule

FILE: hdl/sbr_core.sv
// Register state, buzzer countdown and result register of the block.
`timescale 1ns / 1ps

module sbr_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_stall,
   input  sbr_pkg::sbr_item_type               in_item,
   input  sbr_pkg::sbr_residue_type            in_res,
   input  logic                                csr_write,
   input  logic [sbr_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [7:0]                          csr_wdata,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [7:0]                          rsp_read_byte,
   output logic                                rsp_buzzer_active,
   output logic [3:0]                          rsp_pitch_factor,
   output logic                                rsp_pitch_lower
);
   import sbr_pkg::*;

   // Inverses of the odd parts of the divisors, modulo the result widths.
   localparam logic [3:0] INV_BUZ_NIB   = 4'd9;
   localparam logic [7:0] INV_TIME_BYTE = 8'd97;

   function automatic logic [BUZ_RES_W-1:0] buz_mod_sub(
      input logic [BUZ_RES_W-1:0] a,
      input logic [BUZ_RES_W-1:0] b
   );
      logic [BUZ_RES_W:0] diff;
      diff = {1'b0, a} - {1'b0, b};
      if (diff[BUZ_RES_W]) begin
         diff = diff + (BUZ_RES_W + 1)'(MOD_BUZ);
      end
      return diff[BUZ_RES_W-1:0];
   endfunction

   logic                 power_on_in, power_on_ff;
   logic [7:0]           presence_in, presence_ff;
   logic [CYCLE_W-1:0]   cur_in, cur_ff;
   logic [BUZ_RES_W-1:0] cur_mod_in, cur_mod_ff;
   logic [7:0]           time_byte_in, time_byte_ff;
   logic [CYCLE_W-1:0]   end_in, end_ff;
   logic [BUZ_RES_W-1:0] end_mod_in, end_mod_ff;
   logic [7:0]           buzzer_in, buzzer_ff;
   logic                 sounding_in, sounding_ff;
   logic                 rsp_valid_in, rsp_valid_ff;
   logic [7:0]           rsp_read_in, rsp_read_ff;
   logic                 rsp_active_in, rsp_active_ff;
   logic [3:0]           rsp_factor_in, rsp_factor_ff;
   logic                 rsp_lower_in, rsp_lower_ff;

   logic                 accept;
   logic [7:0]           read_data;
   logic                 end_ahead;
   logic [6:0]           rem_lo;
   logic [BUZ_RES_W-1:0] rem_mod;
   logic [6:0]           quo_lo;
   logic [3:0]           quo_nib;
   logic [3:0]           nibble;
   logic [8:0]           time_lo;
   logic [7:0]           time_byte;
   logic [20:0]          dur_cycles;
   logic [CYCLE_W:0]     end_sum;
   logic [2:0]           pitch;

   assign in_stall = rsp_valid_ff && rsp_stall;
   assign accept   = in_valid && !in_stall;

   always_comb begin
      // Countdown nibble: the remaining time minus its residue is a multiple
      // of the unit, so the quotient's low bits follow from low bits only.
      end_ahead = end_ff > in_item.cpu_cycle;
      rem_lo    = end_ff[6:0] - in_item.cpu_cycle[6:0];
      rem_mod   = buz_mod_sub(end_mod_ff, in_res.buz);
      quo_lo    = rem_lo - rem_mod[6:0];
      quo_nib   = quo_lo[6:3] * INV_BUZ_NIB;
      nibble    = end_ahead ? quo_nib + 4'd1 : 4'd0;

      // Time byte of the new cycle count, by the same exact-division trick.
      time_lo   = in_item.cpu_cycle[8:0] - in_res.tim[8:0];
      time_byte = time_lo[8:1] * INV_TIME_BYTE;

      // End of the buzzer period for a write, tracking its residue on wrap.
      dur_cycles = 21'(in_item.write_byte[7:4]) * 21'(MOD_BUZ);
      end_sum    = (CYCLE_W + 1)'(cur_ff) + (CYCLE_W + 1)'(dur_cycles);

      power_on_in  = power_on_ff;
      presence_in  = presence_ff;
      cur_in       = cur_ff;
      cur_mod_in   = cur_mod_ff;
      time_byte_in = time_byte_ff;
      end_in       = end_ff;
      end_mod_in   = end_mod_ff;
      buzzer_in    = buzzer_ff;
      sounding_in  = sounding_ff;
      read_data    = 8'd0;

      if (accept) begin
         unique case (in_item.action)
            ACT_TICK: begin
               cur_in       = in_item.cpu_cycle;
               cur_mod_in   = in_res.buz;
               time_byte_in = time_byte;
               buzzer_in    = {nibble, buzzer_ff[3:0]};
               if (nibble == 4'd0) begin
                  sounding_in = 1'b0;
               end
            end
            ACT_WRITE: begin
               if (power_on_ff && in_item.reg_index == REG_BUZZER) begin
                  buzzer_in   = in_item.write_byte;
                  end_in      = end_sum[CYCLE_W-1:0];
                  end_mod_in  = end_sum[CYCLE_W] ? buz_mod_sub(cur_mod_ff, KB_WRAP)
                                                 : cur_mod_ff;
                  sounding_in = 1'b1;
               end
            end
            ACT_READ: begin
               if (power_on_ff) begin
                  unique case (in_item.reg_index)
                     REG_PRESENCE: read_data = presence_ff;
                     REG_TIME:     read_data = time_byte_ff;
                     REG_BUZZER:   read_data = buzzer_ff;
                     default:      read_data = 8'd0;
                  endcase
               end
            end
            default: begin
            end
         endcase
      end

      pitch         = buzzer_in[2:0];
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_read_in   = rsp_read_ff;
      rsp_active_in = rsp_active_ff;
      rsp_factor_in = rsp_factor_ff;
      rsp_lower_in  = rsp_lower_ff;
      if (accept) begin
         rsp_valid_in  = 1'b1;
         rsp_read_in   = read_data;
         rsp_active_in = sounding_in;
         rsp_factor_in = (pitch == 3'd0) ? 4'd1 : 4'(pitch) + 4'd1;
         rsp_lower_in  = (pitch != 3'd0) && buzzer_in[3];
      end

      if (csr_write) begin
         unique case (csr_index)
            CSR_POWER_ON: begin
               power_on_in = csr_wdata[0];
               sounding_in = 1'b0;
            end
            CSR_PRESENCE: presence_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         power_on_ff  <= 1'b0;
         presence_ff  <= 8'd0;
         cur_ff       <= '0;
         cur_mod_ff   <= '0;
         time_byte_ff <= 8'd0;
         end_ff       <= '0;
         end_mod_ff   <= '0;
         buzzer_ff    <= 8'd0;
         sounding_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         power_on_ff  <= power_on_in;
         presence_ff  <= presence_in;
         cur_ff       <= cur_in;
         cur_mod_ff   <= cur_mod_in;
         time_byte_ff <= time_byte_in;
         end_ff       <= end_in;
         end_mod_ff   <= end_mod_in;
         buzzer_ff    <= buzzer_in;
         sounding_ff  <= sounding_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_read_ff   <= rsp_read_in;
      rsp_active_ff <= rsp_active_in;
      rsp_factor_ff <= rsp_factor_in;
      rsp_lower_ff  <= rsp_lower_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_byte     = rsp_read_ff;
   assign rsp_buzzer_active = rsp_active_ff;
   assign rsp_pitch_factor  = rsp_factor_ff;
   assign rsp_pitch_lower   = rsp_lower_ff;

endmodule
